### hdl/two_bit_timed_pair_transmitter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-bit timed pair transmitter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TWO_BIT_TIMED_PAIR_TRANSMITTER_MACROS_SVH
`define TWO_BIT_TIMED_PAIR_TRANSMITTER_MACROS_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define TBTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbtp: same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define TBTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbtp: next-cycle check failed");
`else
`define TBTP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TBTP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/tbtp_pkg.sv
// ----------------------------------------------------------------------------
// tbtp_pkg
// Shared types, sizes and codes of the two-bit timed pair transmitter.
// ----------------------------------------------------------------------------
package tbtp_pkg;

    // request kinds as carried on the input tuser
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;
    localparam logic [1:0] MODE_LOAD   = 2'd2;
    localparam logic [1:0] MODE_BLOCK  = 2'd3;

    // byte buffer
    localparam int BUF_DEPTH = 256;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // event time base
    localparam int TIME_W = 16;

    // timing registers
    typedef struct packed {
        logic [9:0] single_first_us;
        logic [9:0] block_first_us;
        logic [7:0] pair_spacing_us;
        logic [7:0] block_gap_us;
        logic [7:0] tail_hold_us;
    } t_cfg;

    // decoded request kind, one-hot
    typedef struct packed {
        logic is_tick;
        logic is_single;
        logic is_load;
        logic is_block;
    } t_kind;

    // one classified request
    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_value;
        logic [7:0] burst_length;
        logic       data_line_in;
        logic       atn_active;
    } t_item;

    // one result, last field in the lowest bit
    typedef struct packed {
        logic aborted;
        logic finished;
        logic busy_res;
        logic data_line_out;
        logic clk_line_out;
    } t_result;

endpackage

### hdl/tbtp_regs.sv
// ----------------------------------------------------------------------------
// tbtp_regs
// APB register file holding the five timing registers.
// ----------------------------------------------------------------------------
module tbtp_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output tbtp_pkg::t_cfg       o_cfg
);
    import tbtp_pkg::*;

    localparam logic [2:0] REG_SINGLE_FIRST = 3'd0;
    localparam logic [2:0] REG_BLOCK_FIRST  = 3'd1;
    localparam logic [2:0] REG_PAIR_SPACING = 3'd2;
    localparam logic [2:0] REG_BLOCK_GAP    = 3'd3;
    localparam logic [2:0] REG_TAIL_HOLD    = 3'd4;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.single_first_us <= 10'd31;
            r_cfg.block_first_us  <= 10'd43;
            r_cfg.pair_spacing_us <= 8'd29;
            r_cfg.block_gap_us    <= 8'd51;
            r_cfg.tail_hold_us    <= 8'd5;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SINGLE_FIRST: r_cfg.single_first_us <= pwdata[9:0];
                REG_BLOCK_FIRST:  r_cfg.block_first_us  <= pwdata[9:0];
                REG_PAIR_SPACING: r_cfg.pair_spacing_us <= pwdata[7:0];
                REG_BLOCK_GAP:    r_cfg.block_gap_us    <= pwdata[7:0];
                REG_TAIL_HOLD:    r_cfg.tail_hold_us    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_SINGLE_FIRST: prdata = {22'd0, r_cfg.single_first_us};
            REG_BLOCK_FIRST:  prdata = {22'd0, r_cfg.block_first_us};
            REG_PAIR_SPACING: prdata = {24'd0, r_cfg.pair_spacing_us};
            REG_BLOCK_GAP:    prdata = {24'd0, r_cfg.block_gap_us};
            REG_TAIL_HOLD:    prdata = {24'd0, r_cfg.tail_hold_us};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/tbtp_front.sv
// ----------------------------------------------------------------------------
// tbtp_front
// Accepts stream requests, decodes their kind and queues them for the back.
// ----------------------------------------------------------------------------
`include "two_bit_timed_pair_transmitter_macros.svh"

module tbtp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_mode,
    input  logic [23:0]          i_data,
    output logic                 o_head_valid,
    output tbtp_pkg::t_item      o_head,
    input  logic                 i_pop
);
    import tbtp_pkg::*;

    t_item               r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;
    t_item               item;
    logic                push;
    logic                pop;

    // classify the request
    always_comb begin
        item.kind.is_tick   = (i_mode == MODE_TICK);
        item.kind.is_single = (i_mode == MODE_SINGLE);
        item.kind.is_load   = (i_mode == MODE_LOAD);
        item.kind.is_block  = (i_mode == MODE_BLOCK);
        item.byte_value     = i_data[7:0];
        item.burst_length   = i_data[15:8];
        item.data_line_in   = i_data[16];
        item.atn_active     = i_data[17];
    end

    assign o_ready      = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push         = i_valid & o_ready;
    assign o_head_valid = (r_count != '0);
    assign pop          = i_pop & o_head_valid;
    assign o_head       = r_queue[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr] <= item;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `TBTP_ASSERT_SAME(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)
    `TBTP_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)
    `TBTP_ASSERT_NEXT(a_both_stable, i_clk, i_rst_n, push && pop, $stable(r_count))

endmodule

### hdl/tbtp_back.sv
// ----------------------------------------------------------------------------
// tbtp_back
// Executes queued requests: handshake waits, tick timing, pair driving,
// the byte buffer, and the registered result slot.
// ----------------------------------------------------------------------------
`include "two_bit_timed_pair_transmitter_macros.svh"

module tbtp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tbtp_pkg::t_cfg       i_cfg,
    input  logic                 i_head_valid,
    input  tbtp_pkg::t_item      i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tbtp_pkg::t_result    o_result
);
    import tbtp_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_WAIT_LOW  = 3'd1;
    localparam logic [2:0] PH_WAIT_HIGH = 3'd2;
    localparam logic [2:0] PH_PAIRS     = 3'd3;
    localparam logic [2:0] PH_ENDING    = 3'd4;
    localparam logic [2:0] PH_TAIL      = 3'd5;

    // transfer state
    logic [2:0]        r_phase,  n_phase;
    logic [TIME_W-1:0] r_tick,   n_tick;
    logic [TIME_W-1:0] r_event,  n_event;
    logic [7:0]        r_shift,  n_shift;
    logic [1:0]        r_pair,   n_pair;
    logic [7:0]        r_left,   n_left;
    logic [BUF_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [BUF_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic              r_block,  n_block;
    logic              r_clk,    n_clk;
    logic              r_dat,    n_dat;
    logic              r_load_pend, n_load_pend;

    // buffer
    logic [7:0]        r_mem [BUF_DEPTH];
    logic [7:0]        r_rd_data;
    logic              load_en;
    logic              wr_en;

    // result slot
    logic              r_out_valid;
    t_result           r_out;

    logic              take;
    logic [7:0]        cur_shift;
    logic [TIME_W-1:0] tick_inc;
    logic [7:0]        left_dec;
    logic              fin;
    logic              abt;

    assign take      = i_head_valid & (~r_out_valid | i_ready);
    assign o_pop     = take;
    assign cur_shift = r_load_pend ? r_rd_data : r_shift;
    assign tick_inc  = r_tick + 1'b1;
    assign left_dec  = r_left - 1'b1;

    function automatic logic [BUF_AW-1:0] ptr_next(input logic [BUF_AW-1:0] p);
        ptr_next = (p == BUF_AW'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // next-state logic for one request
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_event     = r_event;
        n_shift     = cur_shift;
        n_pair      = r_pair;
        n_left      = r_left;
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_block     = r_block;
        n_clk       = r_clk;
        n_dat       = r_dat;
        n_load_pend = 1'b0;
        load_en     = 1'b0;
        wr_en       = 1'b0;
        fin         = 1'b0;
        abt         = 1'b0;
        if (take) begin
            if (i_head.kind.is_single) begin
                if (r_phase == PH_IDLE) begin
                    n_shift = i_head.byte_value;
                    n_block = 1'b0;
                    n_left  = '0;
                    n_pair  = '0;
                    n_phase = PH_WAIT_LOW;
                end
            end else if (i_head.kind.is_load) begin
                wr_en    = 1'b1;
                n_wr_ptr = ptr_next(r_wr_ptr);
            end else if (i_head.kind.is_block) begin
                if (r_phase == PH_IDLE) begin
                    n_block = 1'b1;
                    n_left  = i_head.burst_length;
                    n_pair  = '0;
                    n_phase = PH_WAIT_LOW;
                end
            end else if (r_phase == PH_WAIT_LOW || r_phase == PH_WAIT_HIGH) begin
                // handshake waits
                if (i_head.atn_active) begin
                    abt     = 1'b1;
                    n_phase = PH_IDLE;
                end else if (r_phase == PH_WAIT_LOW) begin
                    if (!i_head.data_line_in) begin
                        n_clk   = 1'b1;
                        n_phase = PH_WAIT_HIGH;
                    end
                end else if (i_head.data_line_in) begin
                    n_tick = '0;
                    if (r_block) begin
                        n_event = TIME_W'(i_cfg.block_first_us);
                        if (r_left == '0) begin
                            n_phase = PH_ENDING;
                        end else begin
                            load_en = 1'b1;
                            n_phase = PH_PAIRS;
                        end
                    end else begin
                        n_event = TIME_W'(i_cfg.single_first_us);
                        n_phase = PH_PAIRS;
                    end
                end
            end else if (r_phase != PH_IDLE) begin
                // timed events
                n_tick = tick_inc;
                if (tick_inc == r_event) begin
                    if (r_phase == PH_PAIRS) begin
                        n_clk   = cur_shift[7];
                        n_dat   = cur_shift[6];
                        n_shift = {cur_shift[5:0], 2'b00};
                        if (r_pair != 2'd3) begin
                            n_pair  = r_pair + 1'b1;
                            n_event = r_event + TIME_W'(i_cfg.pair_spacing_us);
                        end else begin
                            n_pair = '0;
                            if (r_block) begin
                                n_left  = left_dec;
                                n_event = r_event + TIME_W'(i_cfg.block_gap_us);
                                if (left_dec == '0) begin
                                    n_phase = PH_ENDING;
                                end else begin
                                    load_en = 1'b1;
                                end
                            end else begin
                                n_event = r_event + TIME_W'(i_cfg.pair_spacing_us);
                                n_phase = PH_ENDING;
                            end
                        end
                    end else if (r_phase == PH_ENDING) begin
                        n_clk = 1'b0;
                        n_dat = 1'b1;
                        if (i_cfg.tail_hold_us == '0) begin
                            fin     = 1'b1;
                            n_phase = PH_IDLE;
                        end else begin
                            n_event = r_event + TIME_W'(i_cfg.tail_hold_us);
                            n_phase = PH_TAIL;
                        end
                    end else begin
                        fin     = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            if (load_en) begin
                n_rd_ptr    = ptr_next(r_rd_ptr);
                n_load_pend = 1'b1;
            end
        end
    end

    // byte buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_head.byte_value;
        end
        if (load_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_event     <= '0;
            r_shift     <= '0;
            r_pair      <= '0;
            r_left      <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_block     <= 1'b0;
            r_clk       <= 1'b0;
            r_dat       <= 1'b1;
            r_load_pend <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_event     <= n_event;
            r_shift     <= n_shift;
            r_pair      <= n_pair;
            r_left      <= n_left;
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_block     <= n_block;
            r_clk       <= n_clk;
            r_dat       <= n_dat;
            r_load_pend <= n_load_pend;
        end
    end

    // result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= take | (r_out_valid & ~i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.clk_line_out  <= n_clk;
            r_out.data_line_out <= n_dat;
            r_out.busy_res      <= (n_phase != PH_IDLE);
            r_out.finished      <= fin;
            r_out.aborted       <= abt;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `TBTP_ASSERT_SAME(a_flags_excl, i_clk, i_rst_n, r_out_valid, !(r_out.finished && r_out.aborted))
    `TBTP_ASSERT_SAME(a_end_not_busy, i_clk, i_rst_n, r_out_valid && (r_out.finished || r_out.aborted), !r_out.busy_res)
    `TBTP_ASSERT_SAME(a_pend_in_pairs, i_clk, i_rst_n, r_load_pend, r_phase == PH_PAIRS)
    `TBTP_ASSERT_NEXT(a_take_fills, i_clk, i_rst_n, take, r_out_valid)

endmodule

### hdl/two_bit_timed_pair_transmitter.sv
// ----------------------------------------------------------------------------
// two_bit_timed_pair_transmitter
// Two-wire byte sender driving bit pairs on CLK/DATA at tick-counted times.
// ----------------------------------------------------------------------------
// Every request on the input stream yields exactly one result on the output
// stream. The block sustains one request per clock: the front decodes and
// queues up to four requests, and the back executes one per cycle as long as
// its registered result slot is free or being drained; a request passes the
// queue and then the result slot. The byte buffer is a 256-entry memory with
// one write and one registered read port; a buffer read issued by one request
// is folded into the shift register on the following cycle. Timing registers
// are written over APB and should only be changed while no transfer runs.
module two_bit_timed_pair_transmitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] byte_value, [15:8] burst_length,
                                       // [16] data_line_in, [17] atn_active
    input  logic [1:0]  s_axis_tuser,  // [1:0] mode
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [0] clk_line_out, [1] data_line_out,
                                       // [2] busy_res, [3] finished, [4] aborted
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tbtp_pkg::*;

    t_cfg    cfg;
    logic    head_valid;
    t_item   head;
    logic    pop;
    t_result result;

    tbtp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbtp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_mode       (s_axis_tuser),
        .i_data       (s_axis_tdata),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    tbtp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tdata = {3'b000, result};

endmodule
